[rtl/sspd_pkg.sv]
`default_nettype none
package sspd_pkg;

  // default fixed-point fraction width
  localparam int FRAC_BITS_DEF = 16;

  // APB register window: six 32-bit registers at 4*i
  localparam int CFG_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_KP_LIN   = 3'd0,
    REG_KD_LIN   = 3'd1,
    REG_KP_ANG   = 3'd2,
    REG_KD_ANG   = 3'd3,
    REG_CENTRE   = 3'd4,
    REG_INV_STEP = 3'd5
  } reg_idx_t;

  // factor divider sequencer
  typedef enum logic [1:0] {
    DS_IDLE,
    DS_DEN,
    DS_DIV
  } div_state_t;

  // angle constants, 32 fraction bits
  localparam logic [34:0]        TWO_PI_Q32  = 35'd26986075410;
  localparam logic signed [35:0] PI_Q32      = 36'sd13493037705;
  localparam logic signed [35:0] HALF_PI_Q32 = 36'sd6746518852;

  // CORDIC, Q2.30
  localparam int CORDIC_STEPS = 24;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [33:0] ATAN_Q30 [CORDIC_STEPS] = '{
    34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
    34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
    34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
    34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF,
    34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
    34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F
  };

endpackage
`default_nettype wire

[rtl/skid_steer_pd_tracking_control.sv]
// Skid-steer PD trajectory tracking controller.
// Input channel (in_valid / in_stall): one transfer carries current and
// reference pose and speeds; each transfer yields exactly one result on the
// output channel (out_valid / out_stall): linear and angular drive plus a
// saturation flag.
// Throughput: one item per cycle while in_stall is low. From input transfer
// to out_valid an item passes an input register, one stage per bit of the
// Q32 angle reduction, wrap and fold, 24 CORDIC stages, seven
// multiply/round/clip stages and the output register.
// The 1/(xcir^2+1) and xcir/(xcir^2+1) factors come from a radix-2 restoring
// divider that runs after reset and after every write of the centre offset
// register; in_stall is high during that time.
// Reset clears all valid bits and loads the register defaults.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall follows; nothing is dropped or repeated.
// Configuration: APB, registers at byte address 4*i, pready always high;
// write only while the pipeline is empty.
`default_nettype none
module skid_steer_pd_tracking_control #(
  parameter int FRAC_BITS = sspd_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sspd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [31:0]              in_now_x,
  input  logic signed [31:0]              in_now_y,
  input  logic signed [31:0]              in_now_heading,
  input  logic signed [31:0]              in_now_speed,
  input  logic signed [31:0]              in_now_turn_rate,
  input  logic signed [31:0]              in_target_x,
  input  logic signed [31:0]              in_target_y,
  input  logic signed [31:0]              in_target_heading,
  input  logic signed [31:0]              in_target_speed,
  input  logic signed [31:0]              in_target_turn_rate,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              out_drive_linear,
  output logic signed [31:0]              out_drive_angular,
  output logic                            out_saturated
);
  import sspd_pkg::*;

  localparam int SH   = 32 - FRAC_BITS;   // Q32 -> FRAC_BITS shift
  localparam int DPW  = FRAC_BITS + 3;    // wrapped heading error width
  localparam int EVW  = 35;               // rotated error width
  localparam int NST  = SH + 34;          // stages ahead of the output register
  localparam logic signed [31:0] ONE_FX       = 32'sd1 <<< FRAC_BITS;
  localparam logic [30:0]        INV_STEP_RST = 31'(10 << FRAC_BITS);
  localparam logic [64:0]        NUM_G        = 65'd1 << (2 * FRAC_BITS);
  localparam logic [63:0]        DEN_ONE      = 64'd1 << (2 * FRAC_BITS);
  localparam logic signed [36:0] HALF_SH      = 37'sd1 <<< (SH - 1);
  localparam logic signed [64:0] HALF_F       = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic [4:0]         DIV_LAST     = 5'd30;

  // ---------------------------------------------------------------- helpers
  function automatic logic [34:0] res_init(input logic signed [32:0] a);
    logic signed [36:0] t;
    t = 37'(a);
    if (a < 0) t = t + $signed({2'b00, TWO_PI_Q32});
    return t[34:0];
  endfunction

  function automatic logic [34:0] dbl_mod(input logic [34:0] r);
    logic [35:0] t;
    t = {r, 1'b0};
    if (t >= {1'b0, TWO_PI_Q32}) t = t - {1'b0, TWO_PI_Q32};
    return t[34:0];
  endfunction

  function automatic logic signed [35:0] to_angle(input logic [34:0] r);
    logic signed [35:0] t;
    t = $signed({1'b0, r});
    if (t >= PI_Q32) t = t - $signed({1'b0, TWO_PI_Q32});
    return t;
  endfunction

  // {hit, value} clipped to +-(2^31-1)
  function automatic logic [32:0] clip_sym(input logic signed [68:0] v);
    logic [32:0] res;
    if (v > 69'sd2147483647)       res = {1'b1, 32'h7FFF_FFFF};
    else if (v < -69'sd2147483647) res = {1'b1, 32'h8000_0001};
    else                           res = {1'b0, v[31:0]};
    return res;
  endfunction

  // {hit, value} clipped to the signed 32-bit range
  function automatic logic [32:0] clip_full(input logic signed [68:0] v);
    logic [32:0] res;
    if (v > 69'sd2147483647)       res = {1'b1, 32'h7FFF_FFFF};
    else if (v < -69'sd2147483648) res = {1'b1, 32'h8000_0000};
    else                           res = {1'b0, v[31:0]};
    return res;
  endfunction

  // ------------------------------------------------------- config registers
  logic signed [31:0] kp_lin_r, kd_lin_r, kp_ang_r, kd_ang_r, centre_r;
  logic [30:0]        inv_step_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_lin_r   <= ONE_FX;
      kd_lin_r   <= '0;
      kp_ang_r   <= ONE_FX;
      kd_ang_r   <= '0;
      centre_r   <= '0;
      inv_step_r <= INV_STEP_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_KP_LIN:   kp_lin_r   <= pwdata;
        REG_KD_LIN:   kd_lin_r   <= pwdata;
        REG_KP_ANG:   kp_ang_r   <= pwdata;
        REG_KD_ANG:   kd_ang_r   <= pwdata;
        REG_CENTRE:   centre_r   <= pwdata;
        REG_INV_STEP: inv_step_r <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_KP_LIN:   prdata = kp_lin_r;
      REG_KD_LIN:   prdata = kd_lin_r;
      REG_KP_ANG:   prdata = kp_ang_r;
      REG_KD_ANG:   prdata = kd_ang_r;
      REG_CENTRE:   prdata = centre_r;
      REG_INV_STEP: prdata = {1'b0, inv_step_r};
      default:      prdata = '0;
    endcase
  end

  // ------------------------------------------------ centre factor divider
  div_state_t         ds_r, ds_nxt;
  logic [63:0]        den_r, den_nxt;
  logic [64:0]        rg_r, rg_nxt, rh_r, rh_nxt;
  logic [30:0]        qg_r, qg_nxt, qh_r, qh_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [30:0]        g_r, g_nxt;
  logic signed [31:0] h_r, h_nxt;
  logic [31:0]        ax;
  logic [63:0]        ax_sq;
  logic [64:0]        sg, shh;
  logic               bg, bh;
  logic               busy;

  assign ax    = centre_r[31] ? (~centre_r + 32'd1) : centre_r;
  assign ax_sq = ax * ax;
  assign busy  = (ds_r != DS_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) ds_r <= DS_DEN;
    else        ds_r <= ds_nxt;
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    rg_r  <= rg_nxt;
    rh_r  <= rh_nxt;
    qg_r  <= qg_nxt;
    qh_r  <= qh_nxt;
    cnt_r <= cnt_nxt;
    g_r   <= g_nxt;
    h_r   <= h_nxt;
  end

  // one quotient bit per cycle for both factors
  always_comb begin
    ds_nxt  = ds_r;
    den_nxt = den_r;
    rg_nxt  = rg_r;
    rh_nxt  = rh_r;
    qg_nxt  = qg_r;
    qh_nxt  = qh_r;
    cnt_nxt = cnt_r;
    g_nxt   = g_r;
    h_nxt   = h_r;
    sg      = '0;
    shh     = '0;
    bg      = 1'b0;
    bh      = 1'b0;
    unique case (ds_r)
      DS_IDLE: ;
      DS_DEN: begin
        den_nxt = ax_sq + DEN_ONE;
        rg_nxt  = NUM_G;
        rh_nxt  = {33'd0, ax} << FRAC_BITS;
        qg_nxt  = '0;
        qh_nxt  = '0;
        cnt_nxt = '0;
        ds_nxt  = DS_DIV;
      end
      DS_DIV: begin
        sg     = (cnt_r == '0) ? rg_r : {rg_r[63:0], 1'b0};
        shh    = (cnt_r == '0) ? rh_r : {rh_r[63:0], 1'b0};
        bg     = (sg >= {1'b0, den_r});
        bh     = (shh >= {1'b0, den_r});
        rg_nxt = bg ? (sg - {1'b0, den_r}) : sg;
        rh_nxt = bh ? (shh - {1'b0, den_r}) : shh;
        qg_nxt = {qg_r[29:0], bg};
        qh_nxt = {qh_r[29:0], bh};
        if (cnt_r == DIV_LAST) begin
          ds_nxt = DS_IDLE;
          g_nxt  = qg_nxt;
          h_nxt  = centre_r[31] ? -$signed({1'b0, qh_nxt}) : $signed({1'b0, qh_nxt});
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      default: ds_nxt = DS_IDLE;
    endcase
    if (cfg_wr && cfg_idx == REG_CENTRE) ds_nxt = DS_DEN;
  end

  // ------------------------------------------------------ pipeline control
  logic           en, in_acc;
  logic [NST-1:0] vld_r;
  logic           out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = busy || !en;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NST-2:0], in_acc};
      out_valid_r <= vld_r[NST-1];
    end
  end

  // ------------------------------------------------------ stage structures
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [63:0] dvp;
    logic signed [63:0] dwp;
    logic [34:0]        ra;
    logic [34:0]        rd;
  } fr_t;

  typedef struct packed {
    logic signed [32:0]     dx;
    logic signed [32:0]     dy;
    logic signed [63:0]     dvp;
    logic signed [63:0]     dwp;
    logic signed [35:0]     ha;
    logic signed [DPW-1:0]  dpsi;
  } wr_t;

  typedef struct packed {
    logic signed [32:0]     dx;
    logic signed [32:0]     dy;
    logic signed [63:0]     dvp;
    logic signed [63:0]     dwp;
    logic signed [DPW-1:0]  dpsi;
    logic                   flip;
    logic signed [32:0]     x;
    logic signed [32:0]     y;
    logic signed [33:0]     z;
  } cd_t;

  typedef struct packed {
    logic signed [32:0]     dx;
    logic signed [32:0]     dy;
    logic signed [29:0]     c;
    logic signed [29:0]     s;
    logic signed [31:0]     dv;
    logic signed [31:0]     dw;
    logic signed [DPW-1:0]  dpsi;
    logic                   flag;
  } p1_t;

  typedef struct packed {
    logic signed [62:0]     pxc;
    logic signed [62:0]     pys;
    logic signed [62:0]     pyc;
    logic signed [62:0]     pxs;
    logic signed [31:0]     dv;
    logic signed [31:0]     dw;
    logic signed [DPW-1:0]  dpsi;
    logic                   flag;
  } p2_t;

  typedef struct packed {
    logic signed [EVW-1:0]  ev;
    logic signed [EVW-1:0]  t;
    logic signed [31:0]     dv;
    logic signed [31:0]     dw;
    logic signed [DPW-1:0]  dpsi;
    logic                   flag;
  } p3_t;

  typedef struct packed {
    logic signed [31:0]       ev;
    logic signed [66:0]       pht;
    logic signed [31+DPW:0]   pgd;
    logic signed [31:0]       dv;
    logic signed [31:0]       dw;
    logic                     flag;
  } p4_t;

  typedef struct packed {
    logic signed [EVW-1:0]  ew;
    logic signed [63:0]     pkp;
    logic signed [63:0]     pkd;
    logic signed [31:0]     dw;
    logic                   flag;
  } p5_t;

  typedef struct packed {
    logic signed [31:0]  ew;
    logic signed [64:0]  u0;
    logic signed [31:0]  dw;
    logic                flag;
  } p6_t;

  typedef struct packed {
    logic signed [31:0]  u0;
    logic signed [63:0]  pka;
    logic signed [63:0]  pkd;
    logic                flag;
  } p7_t;

  fr_t fr_r [0:SH];
  fr_t fr_nxt [0:SH];
  wr_t wr_r, wr_nxt;
  cd_t cd_r [0:CORDIC_STEPS];
  cd_t cd_nxt [0:CORDIC_STEPS];
  p1_t p1_r, p1_nxt;
  p2_t p2_r, p2_nxt;
  p3_t p3_r, p3_nxt;
  p4_t p4_r, p4_nxt;
  p5_t p5_r, p5_nxt;
  p6_t p6_r, p6_nxt;
  p7_t p7_r, p7_nxt;
  logic signed [31:0] out_lin_r, out_lin_nxt, out_ang_r, out_ang_nxt;
  logic               out_sat_r, out_sat_nxt;

  // input stage: differences, speed error products, angle residues
  logic signed [32:0] dh_in, dsp_in, dtr_in;
  logic signed [31:0] inv_s;

  always_comb begin
    dh_in  = 33'(in_target_heading) - 33'(in_now_heading);
    dsp_in = 33'(in_target_speed) - 33'(in_now_speed);
    dtr_in = 33'(in_target_turn_rate) - 33'(in_now_turn_rate);
    inv_s  = $signed({1'b0, inv_step_r});
    fr_nxt[0].dx  = 33'(in_target_x) - 33'(in_now_x);
    fr_nxt[0].dy  = 33'(in_target_y) - 33'(in_now_y);
    fr_nxt[0].dvp = dsp_in * inv_s;
    fr_nxt[0].dwp = dtr_in * inv_s;
    fr_nxt[0].ra  = res_init(33'(in_now_heading));
    fr_nxt[0].rd  = res_init(dh_in);
  end

  // angle reduction: one doubling mod 2*pi per stage
  for (genvar gk = 1; gk <= SH; gk++) begin : g_wrap
    always_comb begin
      fr_nxt[gk]    = fr_r[gk-1];
      fr_nxt[gk].ra = dbl_mod(fr_r[gk-1].ra);
      fr_nxt[gk].rd = dbl_mod(fr_r[gk-1].rd);
    end
  end

  // wrap into [-pi, pi), round heading error to FRAC_BITS
  logic signed [35:0] ang_d;
  logic signed [36:0] dps_sh;

  always_comb begin
    ang_d         = to_angle(fr_r[SH].rd);
    dps_sh        = (37'(ang_d) + HALF_SH) >>> SH;
    wr_nxt.dx     = fr_r[SH].dx;
    wr_nxt.dy     = fr_r[SH].dy;
    wr_nxt.dvp    = fr_r[SH].dvp;
    wr_nxt.dwp    = fr_r[SH].dwp;
    wr_nxt.ha     = to_angle(fr_r[SH].ra);
    wr_nxt.dpsi   = dps_sh[DPW-1:0];
  end

  // fold into [-pi/2, pi/2], seed CORDIC
  logic signed [35:0] rf;
  logic signed [35:0] rf_q;

  always_comb begin
    cd_nxt[0].flip = 1'b1;
    if (wr_r.ha > HALF_PI_Q32)       rf = wr_r.ha - PI_Q32;
    else if (wr_r.ha < -HALF_PI_Q32) rf = wr_r.ha + PI_Q32;
    else begin
      rf = wr_r.ha;
      cd_nxt[0].flip = 1'b0;
    end
    rf_q           = rf >>> 2;
    cd_nxt[0].dx   = wr_r.dx;
    cd_nxt[0].dy   = wr_r.dy;
    cd_nxt[0].dvp  = wr_r.dvp;
    cd_nxt[0].dwp  = wr_r.dwp;
    cd_nxt[0].dpsi = wr_r.dpsi;
    cd_nxt[0].x    = CORDIC_GAIN;
    cd_nxt[0].y    = '0;
    cd_nxt[0].z    = rf_q[33:0];
  end

  // CORDIC rotation, one iteration per stage
  for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
    always_comb begin
      cd_nxt[gi+1] = cd_r[gi];
      if (cd_r[gi].z >= 0) begin
        cd_nxt[gi+1].x = cd_r[gi].x - (cd_r[gi].y >>> gi);
        cd_nxt[gi+1].y = cd_r[gi].y + (cd_r[gi].x >>> gi);
        cd_nxt[gi+1].z = cd_r[gi].z - ATAN_Q30[gi];
      end else begin
        cd_nxt[gi+1].x = cd_r[gi].x + (cd_r[gi].y >>> gi);
        cd_nxt[gi+1].y = cd_r[gi].y - (cd_r[gi].x >>> gi);
        cd_nxt[gi+1].z = cd_r[gi].z + ATAN_Q30[gi];
      end
    end
  end

  // P1: sin/cos to 28 fraction bits, speed errors rounded and clipped
  logic signed [33:0] xr, yr;
  logic signed [64:0] dv_sh, dw_sh;
  logic [32:0]        dv_cl, dw_cl;

  always_comb begin
    xr    = (34'(cd_r[CORDIC_STEPS].x) + 34'sd2) >>> 2;
    yr    = (34'(cd_r[CORDIC_STEPS].y) + 34'sd2) >>> 2;
    dv_sh = (65'(cd_r[CORDIC_STEPS].dvp) + HALF_F) >>> FRAC_BITS;
    dw_sh = (65'(cd_r[CORDIC_STEPS].dwp) + HALF_F) >>> FRAC_BITS;
    dv_cl = clip_sym(69'(dv_sh));
    dw_cl = clip_sym(69'(dw_sh));
    p1_nxt.dx   = cd_r[CORDIC_STEPS].dx;
    p1_nxt.dy   = cd_r[CORDIC_STEPS].dy;
    p1_nxt.c    = cd_r[CORDIC_STEPS].flip ? 30'(-xr) : 30'(xr);
    p1_nxt.s    = cd_r[CORDIC_STEPS].flip ? 30'(-yr) : 30'(yr);
    p1_nxt.dv   = dv_cl[31:0];
    p1_nxt.dw   = dw_cl[31:0];
    p1_nxt.dpsi = cd_r[CORDIC_STEPS].dpsi;
    p1_nxt.flag = (dv_cl[32] && kd_lin_r != 0) || (dw_cl[32] && kd_ang_r != 0);
  end

  // P2: frame rotation products
  always_comb begin
    p2_nxt.pxc  = p1_r.dx * p1_r.c;
    p2_nxt.pys  = p1_r.dy * p1_r.s;
    p2_nxt.pyc  = p1_r.dy * p1_r.c;
    p2_nxt.pxs  = p1_r.dx * p1_r.s;
    p2_nxt.dv   = p1_r.dv;
    p2_nxt.dw   = p1_r.dw;
    p2_nxt.dpsi = p1_r.dpsi;
    p2_nxt.flag = p1_r.flag;
  end

  // P3: linear error and lateral term
  logic signed [63:0] se_ev, se_t;

  always_comb begin
    se_ev = (64'(p2_r.pxc) + 64'(p2_r.pys) + 64'sd134217728) >>> 28;
    se_t  = (64'(p2_r.pyc) - 64'(p2_r.pxs) + 64'sd134217728) >>> 28;
    p3_nxt.ev   = se_ev[EVW-1:0];
    p3_nxt.t    = se_t[EVW-1:0];
    p3_nxt.dv   = p2_r.dv;
    p3_nxt.dw   = p2_r.dw;
    p3_nxt.dpsi = p2_r.dpsi;
    p3_nxt.flag = p2_r.flag;
  end

  // P4: clip linear error, angular error products
  logic [32:0] ev_cl;

  always_comb begin
    ev_cl       = clip_sym(69'(p3_r.ev));
    p4_nxt.ev   = ev_cl[31:0];
    p4_nxt.pht  = h_r * p3_r.t;
    p4_nxt.pgd  = $signed({1'b0, g_r}) * p3_r.dpsi;
    p4_nxt.dv   = p3_r.dv;
    p4_nxt.dw   = p3_r.dw;
    p4_nxt.flag = p3_r.flag || (ev_cl[32] && kp_lin_r != 0);
  end

  // P5: angular error, linear drive products
  logic signed [67:0] se_ew;

  always_comb begin
    se_ew       = (68'(p4_r.pht) + 68'(p4_r.pgd) + 68'sd536870912) >>> 30;
    p5_nxt.ew   = se_ew[EVW-1:0];
    p5_nxt.pkp  = kp_lin_r * p4_r.ev;
    p5_nxt.pkd  = kd_lin_r * p4_r.dv;
    p5_nxt.dw   = p4_r.dw;
    p5_nxt.flag = p4_r.flag;
  end

  // P6: clip angular error, round linear drive
  logic [32:0] ew_cl;

  always_comb begin
    ew_cl       = clip_sym(69'(p5_r.ew));
    p6_nxt.ew   = ew_cl[31:0];
    p6_nxt.u0   = (65'(p5_r.pkp) + 65'(p5_r.pkd) + HALF_F) >>> FRAC_BITS;
    p6_nxt.dw   = p5_r.dw;
    p6_nxt.flag = p5_r.flag || (ew_cl[32] && kp_ang_r != 0);
  end

  // P7: saturate linear drive, angular drive products
  logic [32:0] u0_cl;

  always_comb begin
    u0_cl       = clip_full(69'(p6_r.u0));
    p7_nxt.u0   = u0_cl[31:0];
    p7_nxt.pka  = kp_ang_r * p6_r.ew;
    p7_nxt.pkd  = kd_ang_r * p6_r.dw;
    p7_nxt.flag = p6_r.flag || u0_cl[32];
  end

  // output: round and saturate angular drive
  logic signed [64:0] u1_sh;
  logic [32:0]        u1_cl;

  always_comb begin
    u1_sh       = (65'(p7_r.pka) + 65'(p7_r.pkd) + HALF_F) >>> FRAC_BITS;
    u1_cl       = clip_full(69'(u1_sh));
    out_lin_nxt = p7_r.u0;
    out_ang_nxt = u1_cl[31:0];
    out_sat_nxt = p7_r.flag || u1_cl[32];
  end

  // payload registers advance with the valid chain
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= SH; k++) fr_r[k] <= fr_nxt[k];
      wr_r <= wr_nxt;
      for (int j = 0; j <= CORDIC_STEPS; j++) cd_r[j] <= cd_nxt[j];
      p1_r      <= p1_nxt;
      p2_r      <= p2_nxt;
      p3_r      <= p3_nxt;
      p4_r      <= p4_nxt;
      p5_r      <= p5_nxt;
      p6_r      <= p6_nxt;
      p7_r      <= p7_nxt;
      out_lin_r <= out_lin_nxt;
      out_ang_r <= out_ang_nxt;
      out_sat_r <= out_sat_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_linear  = out_lin_r;
  assign out_drive_angular = out_ang_r;
  assign out_saturated     = out_sat_r;

endmodule
`default_nettype wire

[rtl/sspd_checker.sv]
`default_nettype none
module sspd_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [sspd_pkg::CFG_ADDR_W-1:0] paddr,
  input logic                            pready,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [31:0]              out_drive_linear,
  input logic signed [31:0]              out_drive_angular,
  input logic                            out_saturated
);
  import sspd_pkg::*;

  // no result right after reset
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  // factor divider starts at reset, so input is held off
  a_rst_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // new centre offset restarts the divider
  a_centre_stall: assert property (@(posedge clk)
    rst_n && psel && penable && pwrite && pready && paddr[4:2] == REG_CENTRE |=> in_stall)
    else $error("input not stalled after centre offset write");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive_linear) &&
      $stable(out_drive_angular) && $stable(out_saturated))
    else $error("stalled result changed");

endmodule

bind skid_steer_pd_tracking_control sspd_checker u_sspd_checker (.*);
`default_nettype wire
